@@ rtl/mau_pkg.sv @@
// Package for the modular arithmetic unit: widths, operation codes and sequencer states.
// Depends on nothing; used by the channel interfaces and the core.
`default_nettype none
package mau_pkg;
   localparam int MOD_WIDTH_DEFAULT = 31;
   localparam int MODULUS_RESET = 1000000007;
   localparam int KIND_WIDTH = 3;
   localparam int EXP_WIDTH = 64;
   localparam int RAW_WIDTH = 64;

   typedef enum logic [2:0] {
      KIND_ADD    = 3'd0,
      KIND_SUB    = 3'd1,
      KIND_MUL    = 3'd2,
      KIND_DIV    = 3'd3,
      KIND_POW    = 3'd4,
      KIND_NEG    = 3'd5,
      KIND_REDUCE = 3'd6,
      KIND_NONE   = 3'd7
   } kind_type;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_PREP   = 7'b0000010,
      ST_SETUP  = 7'b0000100,
      ST_MULRUN = 7'b0001000,
      ST_STEP   = 7'b0010000,
      ST_FINAL  = 7'b0100000,
      ST_DONE   = 7'b1000000
   } state_type;
endpackage
`default_nettype wire

@@ rtl/mau_if.sv @@
// Valid/ready channel interfaces for requests and responses of the modular arithmetic unit.
// Depends on mau_pkg.
`default_nettype none
interface mau_req_if #(parameter int MOD_WIDTH = mau_pkg::MOD_WIDTH_DEFAULT);
   logic                            valid;
   logic                            ready;
   logic [mau_pkg::KIND_WIDTH-1:0]  kind;
   logic                            reduce_request;
   logic [30:0]                     left_operand;
   logic [30:0]                     right_operand;
   logic [mau_pkg::EXP_WIDTH-1:0]   exponent;
   logic signed [mau_pkg::RAW_WIDTH-1:0] raw_value;
   modport source (output valid, kind, reduce_request, left_operand, right_operand,
                   exponent, raw_value, input ready);
   modport sink (input valid, kind, reduce_request, left_operand, right_operand,
                 exponent, raw_value, output ready);
endinterface

interface mau_rsp_if #(parameter int MOD_WIDTH = mau_pkg::MOD_WIDTH_DEFAULT);
   logic                 valid;
   logic                 ready;
   logic [MOD_WIDTH-1:0] result;
   modport source (output valid, result, input ready);
   modport sink (input valid, result, output ready);
endinterface
`default_nettype wire

@@ rtl/modular_arithmetic_unit_core.sv @@
// Top level of the modular arithmetic unit: one shared bit-serial modular multiplier/reducer
// driven by a small sequencer. Depends on mau_pkg and the interfaces in mau_if.sv.
//
//  channel | modport | fields
//  req     | sink    | kind, reduce_request, left_operand, right_operand, exponent, raw_value
//  rsp     | source  | result
//  csr     | (none)  | csr_we, csr_wdata (modulus)
//
// Every modular multiply and every reduction runs through one shift-and-add unit, one bit a
// cycle; a reduction takes a 64-bit raw value. Both operands are reduced first. Power then
// multiplies and squares for each set exponent bit and only squares for each clear bit, up
// to the top set bit; divide runs power on modulus minus 2 and one closing multiply.
// The request side is ready whenever the sequencer is idle; a finished result waits in its
// own register, and only a second finished result stalls while the response side holds off.
// Reset is synchronous and restores the modulus to its reset value.
`default_nettype none
module modular_arithmetic_unit_core #(
   parameter int MOD_WIDTH = mau_pkg::MOD_WIDTH_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_we,
   input  wire logic [MOD_WIDTH-1:0] csr_wdata,
   mau_req_if.sink                   req,
   mau_rsp_if.source                 rsp
);
   localparam int W = MOD_WIDTH;
   localparam int OPW = 31;
   localparam int EW = mau_pkg::EXP_WIDTH;
   localparam int CW = $clog2(EW + 2);

   mau_pkg::state_type state_ff, state_in;
   logic [W-1:0] modulus_ff;
   logic [W-1:0] x_ff, x_in, y_ff, y_in;
   logic [W-1:0] acc_ff, acc_in, base_ff, base_in;
   logic [EW-1:0] exp_ff, exp_in;
   mau_pkg::kind_type kind_ff, kind_in;
   logic neg_ff, neg_in;
   // Shared unit: accumulate ma_ff * mb_ff (or reduce a bit stream) MSB first.
   logic [EW-1:0] mb_ff, mb_in;
   logic [W-1:0] ma_ff, ma_in, mr_ff, mr_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W-1:0] res_ff, res_in;
   logic [W-1:0] out_ff, out_in;
   logic [OPW-1:0] ro_ff, ro_in;
   logic rvalid_ff, rvalid_in;
   logic [2:0] phase_ff, phase_in;

   logic [W+1:0] dbl, dbl_r, add_v, add_r;
   logic [W-1:0] step_out;
   logic [W:0] sum2;
   logic [OPW-1:0] lo_op, ro_op;
   logic [EW-1:0] mag;

   // Phase codes for which multiply the unit performs.
   localparam logic [2:0] PH_RX = 3'd0, PH_RY = 3'd1, PH_MAIN = 3'd2, PH_SQR = 3'd3,
                          PH_MUL = 3'd4, PH_FIN = 3'd5;

   assign req.ready = (state_ff == mau_pkg::ST_IDLE);
   assign rsp.valid = rvalid_ff;
   assign rsp.result = out_ff;

   always_comb begin
      // One step: r = 2r + bit*a, reduced by up to two subtractions.
      dbl = {1'b0, mr_ff, 1'b0};
      dbl_r = (dbl >= {2'b00, modulus_ff}) ? dbl - {2'b00, modulus_ff} : dbl;
      add_v = dbl_r + (mb_ff[EW-1] ? {2'b00, ma_ff} : '0);
      add_r = (add_v >= {2'b00, modulus_ff}) ? add_v - {2'b00, modulus_ff} : add_v;
      step_out = add_r[W-1:0];
   end

   always_comb begin
      state_in = state_ff;
      x_in = x_ff; y_in = y_ff; acc_in = acc_ff; base_in = base_ff; exp_in = exp_ff;
      kind_in = kind_ff; neg_in = neg_ff;
      mb_in = mb_ff; ma_in = ma_ff; mr_in = mr_ff; cnt_in = cnt_ff;
      res_in = res_ff; out_in = out_ff; ro_in = ro_ff;
      rvalid_in = rvalid_ff; phase_in = phase_ff;
      sum2 = '0;
      lo_op = req.left_operand;
      ro_op = req.right_operand;
      mag = req.raw_value[EW-1] ? EW'(0) - req.raw_value : req.raw_value;
      if (rvalid_ff && rsp.ready) rvalid_in = 1'b0;
      unique case (state_ff)
         mau_pkg::ST_IDLE: begin
            if (req.valid && req.ready) begin
               if (req.reduce_request || req.kind == mau_pkg::KIND_REDUCE)
                  kind_in = mau_pkg::KIND_REDUCE;
               else
                  kind_in = mau_pkg::kind_type'(req.kind);
               neg_in = req.raw_value[EW-1];
               exp_in = req.exponent;
               // Both operands are reduced through the unit as well;
               // the right operand waits in its own register until the left one is done.
               mb_in = EW'(lo_op) << (EW - OPW);
               ma_in = W'(1);
               mr_in = '0;
               cnt_in = CW'(OPW);
               phase_in = PH_RX;
               ro_in = ro_op;
               acc_in = '0;
               base_in = '0;
               x_in = '0;
               y_in = '0;
               state_in = mau_pkg::ST_MULRUN;
               if (modulus_ff < W'(2)) begin
                  kind_in = mau_pkg::KIND_NONE;
                  state_in = mau_pkg::ST_FINAL;
               end else if (kind_in == mau_pkg::KIND_REDUCE) begin
                  mb_in = mag;
                  cnt_in = CW'(EW);
                  phase_in = PH_FIN;
               end
            end
         end
         mau_pkg::ST_MULRUN: begin
            mr_in = step_out;
            mb_in = {mb_ff[EW-2:0], 1'b0};
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) state_in = mau_pkg::ST_STEP;
         end
         mau_pkg::ST_STEP: begin
            state_in = mau_pkg::ST_MULRUN;
            ma_in = '0;
            mr_in = '0;
            cnt_in = CW'(W);
            mb_in = '0;
            unique case (phase_ff)
               PH_RX: begin
                  x_in = mr_ff;
                  mb_in = EW'(ro_ff) << (EW - OPW);
                  ma_in = W'(1);
                  cnt_in = CW'(OPW);
                  phase_in = PH_RY;
               end
               PH_RY: begin
                  y_in = mr_ff;
                  acc_in = W'(1);
                  unique case (kind_ff)
                     mau_pkg::KIND_MUL: begin
                        mb_in = EW'(x_ff) << (EW - W);
                        ma_in = mr_ff;
                        phase_in = PH_FIN;
                     end
                     mau_pkg::KIND_DIV, mau_pkg::KIND_POW: begin
                        base_in = (kind_ff == mau_pkg::KIND_DIV) ? mr_ff : x_ff;
                        exp_in = (kind_ff == mau_pkg::KIND_DIV) ?
                                 EW'(modulus_ff - W'(2)) : exp_ff;
                        if (kind_ff == mau_pkg::KIND_DIV && mr_ff == '0) begin
                           res_in = '0;
                           state_in = mau_pkg::ST_DONE;
                        end else begin
                           state_in = mau_pkg::ST_SETUP;
                        end
                     end
                     default: state_in = mau_pkg::ST_FINAL;
                  endcase
               end
               PH_MUL: begin
                  acc_in = mr_ff;
                  mb_in = EW'(base_ff) << (EW - W);
                  ma_in = base_ff;
                  phase_in = PH_SQR;
               end
               PH_SQR: begin
                  base_in = mr_ff;
                  exp_in = exp_ff >> 1;
                  state_in = mau_pkg::ST_SETUP;
               end
               PH_MAIN: begin
                  res_in = mr_ff;
                  state_in = mau_pkg::ST_DONE;
               end
               default: begin
                  res_in = mr_ff;
                  if (kind_ff == mau_pkg::KIND_REDUCE && neg_ff && mr_ff != '0)
                     res_in = modulus_ff - mr_ff;
                  state_in = mau_pkg::ST_DONE;
               end
            endcase
         end
         mau_pkg::ST_SETUP: begin
            // One square-and-multiply step, divide's closing multiply, or power's end.
            state_in = mau_pkg::ST_MULRUN;
            mr_in = '0;
            cnt_in = CW'(W);
            if (exp_ff == '0) begin
               if (kind_ff == mau_pkg::KIND_DIV) begin
                  mb_in = EW'(x_ff) << (EW - W);
                  ma_in = acc_ff;
                  phase_in = PH_MAIN;
               end else begin
                  res_in = acc_ff;
                  state_in = mau_pkg::ST_DONE;
               end
            end else if (exp_ff[0]) begin
               mb_in = EW'(acc_ff) << (EW - W);
               ma_in = base_ff;
               phase_in = PH_MUL;
            end else begin
               mb_in = EW'(base_ff) << (EW - W);
               ma_in = base_ff;
               phase_in = PH_SQR;
            end
         end
         mau_pkg::ST_FINAL: begin
            res_in = '0;
            sum2 = {1'b0, x_ff} + {1'b0, y_ff};
            unique case (kind_ff)
               mau_pkg::KIND_ADD:
                  res_in = (sum2 >= {1'b0, modulus_ff}) ? W'(sum2 - {1'b0, modulus_ff})
                                                         : W'(sum2);
               mau_pkg::KIND_SUB: begin
                  sum2 = {1'b0, x_ff} + {1'b0, modulus_ff - y_ff};
                  res_in = (sum2 >= {1'b0, modulus_ff}) ? W'(sum2 - {1'b0, modulus_ff})
                                                         : W'(sum2);
               end
               mau_pkg::KIND_NEG: res_in = (x_ff == '0) ? '0 : modulus_ff - x_ff;
               default: res_in = '0;
            endcase
            state_in = mau_pkg::ST_DONE;
         end
         mau_pkg::ST_DONE: begin
            // The result moves to the output register once the previous one has left.
            if (!rvalid_ff || rsp.ready) begin
               rvalid_in = 1'b1;
               out_in = res_ff;
               state_in = mau_pkg::ST_IDLE;
            end
         end
         default: state_in = mau_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mau_pkg::ST_IDLE;
         rvalid_ff <= 1'b0;
         modulus_ff <= W'(mau_pkg::MODULUS_RESET);
      end else begin
         state_ff <= state_in;
         rvalid_ff <= rvalid_in;
         if (csr_we) modulus_ff <= csr_wdata;
      end
      x_ff <= x_in; y_ff <= y_in; acc_ff <= acc_in; base_ff <= base_in; exp_ff <= exp_in;
      kind_ff <= kind_in; neg_ff <= neg_in; mb_ff <= mb_in; ma_ff <= ma_in;
      mr_ff <= mr_in; cnt_ff <= cnt_in; res_ff <= res_in; out_ff <= out_in; ro_ff <= ro_in;
      phase_ff <= phase_in;
   end
endmodule
`default_nettype wire
